FILE: sv/ouart_pkg.sv
// Package for the oversampled UART with transmit and receive FIFOs.
// Holds sizes, derived widths, timing constants, codes and channel payload types.
// No dependencies.
package ouart_pkg;

    // Sizes
    localparam int OVERSAMPLE_TICKS = 8;
    localparam int RX_DEPTH         = 64;
    localparam int TX_DEPTH         = 64;

    // Derived widths
    localparam int RX_PTR_W  = $clog2(RX_DEPTH);
    localparam int RX_CNT_W  = $clog2(RX_DEPTH + 1);
    localparam int TX_PTR_W  = $clog2(TX_DEPTH);
    localparam int TX_CNT_W  = $clog2(TX_DEPTH + 1);
    localparam int RX_WAIT_W = 5;
    localparam int TX_WAIT_W = 6;
    localparam int BIT_IDX_W = 4;
    localparam int TX_BC_W   = 7;
    localparam int FRAME_W   = 10;
    localparam int LEVEL_W   = 7;
    localparam int CFG_IDX_W = 1;

    // Bit timing
    localparam logic [RX_WAIT_W-1:0] RX_FIRST_WAIT = RX_WAIT_W'(OVERSAMPLE_TICKS + 1);
    localparam logic [RX_WAIT_W-1:0] RX_BIT_WAIT   = RX_WAIT_W'(OVERSAMPLE_TICKS);
    localparam logic [RX_WAIT_W-1:0] RX_REARM_WAIT = RX_WAIT_W'(2);
    localparam logic [TX_WAIT_W-1:0] TX_BIT_WAIT   = TX_WAIT_W'(OVERSAMPLE_TICKS);

    // Receiver bit index: 0..7 data, 8 stop, 15 hunting for start
    localparam logic [BIT_IDX_W-1:0] RX_STOP_IDX = BIT_IDX_W'(8);
    localparam logic [BIT_IDX_W-1:0] RX_HUNTING  = BIT_IDX_W'(15);

    // Transmit frame and inter-frame gap, in bit counter units
    localparam logic [TX_BC_W-1:0] TX_FRAME_BITS = TX_BC_W'(FRAME_W);
    localparam logic [TX_BC_W-1:0] TX_GAP_LIMIT  = TX_BC_W'(FRAME_W + OVERSAMPLE_TICKS * 5);
    localparam logic [TX_BC_W-1:0] TX_BC_MAX     = '1;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_PUSH  = 2'd1,
        FN_POP   = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        PH_CHECK  = 4'b0001,
        PH_SEND_N = 4'b0010,
        PH_SEND_I = 4'b0100,
        PH_GAP    = 4'b1000
    } t_tx_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INVERSE     = 1'b0,
        REG_HALF_DUPLEX = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_func       func;
        logic        rx_line;
        logic [7:0]  tx_data;
        logic        start_tx;
    } t_in_item;

    typedef struct packed {
        logic               tx_line;
        logic               tx_drive;
        logic [7:0]         rx_data;
        logic               rx_valid;
        logic               push_ok;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_room;
        logic               rx_overflow;
    } t_out_item;

endpackage

FILE: sv/ouart_if.sv
// Channel interfaces for the oversampled UART: item in, result out, register write.
// Depends on ouart_pkg.
interface ouart_in_if;
    import ouart_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ouart_out_if;
    import ouart_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ouart_cfg_if;
    import ouart_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    logic     wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/oversampled_uart_with_fifos.sv
// An accepted transaction goes from the input register through one pass of update logic
// to the result register. Throughput: one transaction per cycle while o_out is not stalled.
// The FIFO front entries are prefetched into registers each cycle.
// Reset (i_rst_n low at an edge) resets state registers, pointers and flags; payload and
// front registers and FIFO storage are not cleared and never need to be. Register writes are taken in any cycle.
// Depends on ouart_pkg and ouart_if.
module oversampled_uart_with_fifos (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ouart_in_if.sink       i_in,
    ouart_out_if.source    o_out,
    ouart_cfg_if.sink      i_cfg
);
    import ouart_pkg::*;

    localparam logic [RX_CNT_W-1:0] RX_FULL     = RX_CNT_W'(RX_DEPTH);
    localparam logic [TX_CNT_W-1:0] TX_FULL     = TX_CNT_W'(TX_DEPTH);
    localparam logic [RX_PTR_W-1:0] RX_PTR_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_PTR_LAST = TX_PTR_W'(TX_DEPTH - 1);

    // Handshake stages
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      fire;

    // Configuration
    logic r_inverse;
    logic r_half_duplex;

    // Receiver
    logic [RX_WAIT_W-1:0] r_rx_wait,    n_rx_wait;
    logic [BIT_IDX_W-1:0] r_rx_bit_idx, n_rx_bit_idx;
    logic [7:0]           r_rx_shift,   n_rx_shift;

    // Transmitter
    logic [TX_WAIT_W-1:0] r_tx_wait,    n_tx_wait;
    t_tx_phase            r_tx_phase,   n_tx_phase;
    logic [TX_BC_W-1:0]   r_tx_bc,      n_tx_bc;
    logic [FRAME_W-1:0]   r_tx_shift,   n_tx_shift;
    logic                 r_line_out,   n_line_out;

    // Direction and status
    logic r_act_in,  n_act_in;
    logic r_act_out, n_act_out;
    logic r_ovf,     n_ovf;

    // FIFO pointers
    logic [RX_PTR_W-1:0] r_rx_head,  n_rx_head;
    logic [RX_PTR_W-1:0] r_rx_tail,  n_rx_tail;
    logic [RX_CNT_W-1:0] r_rx_count, n_rx_count;
    logic [TX_PTR_W-1:0] r_tx_head,  n_tx_head;
    logic [TX_PTR_W-1:0] r_tx_tail,  n_tx_tail;
    logic [TX_CNT_W-1:0] r_tx_count, n_tx_count;

    // FIFO storage and prefetched front entries
    logic [7:0]          rx_mem [RX_DEPTH];
    logic [7:0]          tx_mem [TX_DEPTH];
    logic [7:0]          r_rx_front;
    logic [7:0]          r_tx_front;
    logic                rx_wr, tx_wr;
    logic                rx_wr_en, tx_wr_en;
    logic [RX_PTR_W-1:0] rx_rd_addr;
    logic [TX_PTR_W-1:0] tx_rd_addr;

    logic      rx_bit;
    t_out_item n_out;

    assign fire        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || fire;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    // One transaction's worth of state update
    always_comb begin
        n_rx_wait    = r_rx_wait;
        n_rx_bit_idx = r_rx_bit_idx;
        n_rx_shift   = r_rx_shift;
        n_tx_wait    = r_tx_wait;
        n_tx_phase   = r_tx_phase;
        n_tx_bc      = r_tx_bc;
        n_tx_shift   = r_tx_shift;
        n_line_out   = r_line_out;
        n_act_in     = r_act_in;
        n_act_out    = r_act_out;
        n_ovf        = r_ovf;
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_rx_count   = r_rx_count;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_count   = r_tx_count;
        rx_wr        = 1'b0;
        tx_wr        = 1'b0;
        rx_bit       = r_in.rx_line ^ r_inverse;
        n_out        = '0;

        case (r_in.func)
            FN_TICK: begin
                if (r_act_in) begin
                    if (r_rx_wait > RX_WAIT_W'(1)) begin
                        n_rx_wait = r_rx_wait - 1'b1;
                    end else begin
                        n_rx_wait = '0;
                        if (r_rx_bit_idx > RX_STOP_IDX) begin
                            if (rx_bit) begin
                                n_rx_wait = RX_WAIT_W'(1);
                            end else begin
                                n_rx_bit_idx = '0;
                                n_rx_wait    = RX_FIRST_WAIT;
                                n_rx_shift   = '0;
                            end
                        end else if (r_rx_bit_idx < RX_STOP_IDX) begin
                            n_rx_shift   = {rx_bit, r_rx_shift[7:1]};
                            n_rx_bit_idx = r_rx_bit_idx + 1'b1;
                            n_rx_wait    = RX_BIT_WAIT;
                        end else begin
                            // stop bit: good framing pushes the byte, or sets overflow if the FIFO is full
                            if (rx_bit) begin
                                if (r_rx_count < RX_FULL) begin
                                    rx_wr      = 1'b1;
                                    n_rx_head  = (r_rx_head == RX_PTR_LAST) ? '0
                                                                            : r_rx_head + 1'b1;
                                    n_rx_count = r_rx_count + 1'b1;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                            n_rx_wait    = RX_WAIT_W'(1);
                            n_rx_bit_idx = RX_HUNTING;
                        end
                    end
                end
                if (r_act_out) begin
                    if (r_tx_wait > TX_WAIT_W'(1)) begin
                        n_tx_wait = r_tx_wait - 1'b1;
                    end else begin
                        n_tx_wait = '0;
                        case (r_tx_phase)
                            PH_CHECK: begin
                                if (r_tx_count != '0) begin
                                    n_tx_tail  = (r_tx_tail == TX_PTR_LAST) ? '0
                                                                            : r_tx_tail + 1'b1;
                                    n_tx_count = r_tx_count - 1'b1;
                                    n_tx_shift = {1'b1, r_tx_front, 1'b0};
                                    n_tx_bc    = '0;
                                    n_tx_wait  = TX_BIT_WAIT;
                                    n_tx_phase = r_inverse ? PH_SEND_I : PH_SEND_N;
                                end else if (r_half_duplex) begin
                                    // turn the line round to receive
                                    n_rx_bit_idx = RX_HUNTING;
                                    n_rx_wait    = RX_REARM_WAIT;
                                    n_act_out    = 1'b0;
                                    n_act_in     = 1'b1;
                                end else begin
                                    n_act_out = 1'b0;
                                end
                            end
                            PH_SEND_N, PH_SEND_I: begin
                                if (r_tx_bc < TX_FRAME_BITS) begin
                                    n_line_out = r_tx_shift[0] ^ (r_tx_phase == PH_SEND_I);
                                    n_tx_shift = {1'b0, r_tx_shift[FRAME_W-1:1]};
                                    n_tx_wait  = TX_BIT_WAIT;
                                end else begin
                                    n_tx_phase = PH_GAP;
                                end
                                n_tx_bc = r_tx_bc + 1'b1;
                            end
                            default: begin
                                if (r_tx_bc > TX_GAP_LIMIT) begin
                                    n_tx_phase = PH_CHECK;
                                end
                                if (r_tx_bc < TX_BC_MAX) begin
                                    n_tx_bc = r_tx_bc + 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            FN_PUSH: begin
                if (r_tx_count < TX_FULL) begin
                    tx_wr         = 1'b1;
                    n_tx_head     = (r_tx_head == TX_PTR_LAST) ? '0 : r_tx_head + 1'b1;
                    n_tx_count    = r_tx_count + 1'b1;
                    n_out.push_ok = 1'b1;
                    if (r_half_duplex) begin
                        n_line_out = ~r_inverse;
                        n_act_in   = 1'b0;
                        n_act_out  = 1'b1;
                    end else if (r_in.start_tx) begin
                        n_act_out = 1'b1;
                    end
                end
            end
            FN_POP: begin
                if (r_rx_count != '0) begin
                    n_out.rx_data  = r_rx_front;
                    n_out.rx_valid = 1'b1;
                    n_rx_tail      = (r_rx_tail == RX_PTR_LAST) ? '0 : r_rx_tail + 1'b1;
                    n_rx_count     = r_rx_count - 1'b1;
                end
            end
            default: begin
                n_rx_head  = '0;
                n_rx_tail  = '0;
                n_rx_count = '0;
                n_tx_head  = '0;
                n_tx_tail  = '0;
                n_tx_count = '0;
            end
        endcase

        n_out.tx_line     = n_line_out;
        n_out.tx_drive    = r_half_duplex ? n_act_out : 1'b1;
        n_out.rx_level    = LEVEL_W'(n_rx_count);
        n_out.tx_room     = LEVEL_W'(TX_FULL - n_tx_count);
        n_out.rx_overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_inverse     <= 1'b0;
            r_half_duplex <= 1'b0;
            r_rx_wait     <= RX_WAIT_W'(1);
            r_rx_bit_idx  <= RX_HUNTING;
            r_rx_shift    <= '0;
            r_tx_wait     <= '0;
            r_tx_phase    <= PH_CHECK;
            r_tx_bc       <= '0;
            r_tx_shift    <= '0;
            r_line_out    <= 1'b1;
            r_act_in      <= 1'b1;
            r_act_out     <= 1'b0;
            r_ovf         <= 1'b0;
            r_rx_head     <= '0;
            r_rx_tail     <= '0;
            r_rx_count    <= '0;
            r_tx_head     <= '0;
            r_tx_tail     <= '0;
            r_tx_count    <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_INVERSE:     r_inverse     <= i_cfg.wdata;
                    REG_HALF_DUPLEX: r_half_duplex <= i_cfg.wdata;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_rx_wait    <= n_rx_wait;
                r_rx_bit_idx <= n_rx_bit_idx;
                r_rx_shift   <= n_rx_shift;
                r_tx_wait    <= n_tx_wait;
                r_tx_phase   <= n_tx_phase;
                r_tx_bc      <= n_tx_bc;
                r_tx_shift   <= n_tx_shift;
                r_line_out   <= n_line_out;
                r_act_in     <= n_act_in;
                r_act_out    <= n_act_out;
                r_ovf        <= n_ovf;
                r_rx_head    <= n_rx_head;
                r_rx_tail    <= n_rx_tail;
                r_rx_count   <= n_rx_count;
                r_tx_head    <= n_tx_head;
                r_tx_tail    <= n_tx_tail;
                r_tx_count   <= n_tx_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // FIFO storage; front entry follows the next tail, with write bypass for an empty FIFO
    assign rx_wr_en   = fire && rx_wr;
    assign tx_wr_en   = fire && tx_wr;
    assign rx_rd_addr = fire ? n_rx_tail : r_rx_tail;
    assign tx_rd_addr = fire ? n_tx_tail : r_tx_tail;

    always_ff @(posedge i_clk) begin
        if (rx_wr_en) begin
            rx_mem[r_rx_head] <= r_rx_shift;
        end
        r_rx_front <= (rx_wr_en && (r_rx_head == rx_rd_addr)) ? r_rx_shift
                                                               : rx_mem[rx_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tx_wr_en) begin
            tx_mem[r_tx_head] <= r_in.tx_data;
        end
        r_tx_front <= (tx_wr_en && (r_tx_head == tx_rd_addr)) ? r_in.tx_data
                                                               : tx_mem[tx_rd_addr];
    end

    // Checks
    a_rx_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_count == '0 || r_rx_count == RX_FULL) |-> (r_rx_head == r_rx_tail))
        else $error("rx FIFO pointers disagree with count");

    a_tx_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_count == '0 || r_tx_count == TX_FULL) |-> (r_tx_head == r_tx_tail))
        else $error("tx FIFO pointers disagree with count");

    a_tx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_phase != PH_CHECK) |-> r_act_out)
        else $error("transmitter mid-frame while disabled");

    a_rx_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_wait <= RX_FIRST_WAIT)
        else $error("rx wait counter out of range");

endmodule
